>>> hdl/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;

	// sizes fixed by the stream fields
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int KERNEL        = 3;
	localparam int PIX_W         = 16;
	localparam int COEF_W        = 16;
	localparam int PROD_W        = 32;
	localparam int ROWSUM_W      = 34;
	localparam int SUM_W         = 36;
	localparam int OUT_TDATA_W   = 40;
	localparam int CNT_W         = 14;
	localparam int ROW_W         = 12;
	localparam int MAX_HEIGHT    = 4096;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// configuration port
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;
	localparam int COEF_ROW_W = 48;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;

	localparam logic [2:0] REG_COEF_TOP    = 3'd0;
	localparam logic [2:0] REG_COEF_MID    = 3'd1;
	localparam logic [2:0] REG_COEF_BOTTOM = 3'd2;
	localparam logic [2:0] REG_WIDTH       = 3'd3;
	localparam logic [2:0] REG_HEIGHT      = 3'd4;

	localparam logic [FW_W-1:0] FW_RESET = 11'd7;
	localparam logic [FH_W-1:0] FH_RESET = 13'd7;

	// one pixel with its window column, as handed from front to back
	typedef struct packed {
		logic signed [PIX_W-1:0] top;
		logic signed [PIX_W-1:0] mid;
		logic signed [PIX_W-1:0] px;
		logic                    emit;
		logic                    last;
	} lbc_item_t;

	typedef logic [KERNEL-1:0][COEF_ROW_W-1:0] coef_t;

endpackage

>>> hdl/lbc_front.sv
`timescale 1ns / 1ps
module lbc_front import lbc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic signed [PIX_W-1:0] pixel,
	input  logic [FW_W-1:0]         frame_width,
	input  logic [FH_W-1:0]         frame_height,
	output logic                    push,
	output lbc_item_t               push_item,
	input  logic                    fifo_full
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	logic [AW-1:0]        x_q;
	logic [ROW_W-1:0]     y_q;
	logic                 clr_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [CNT_W-1:0]     w_eff;
	logic [CNT_W-1:0]     h_eff;
	logic                 row_end;
	logic                 frame_end;
	logic                 accept;
	logic                 fwd_hit;

	logic                    v_s1;
	logic [AW-1:0]           x_s1;
	logic signed [PIX_W-1:0] px_s1;
	logic                    y1_s1;
	logic                    y2_s1;
	logic                    emit_s1;
	logic                    last_s1;
	logic                    fwd_s1;
	logic [2*PIX_W-1:0]      rd_q;
	logic [2*PIX_W-1:0]      fwd_data_q;
	logic [2*PIX_W-1:0]      rdata;
	logic signed [PIX_W-1:0] top;
	logic signed [PIX_W-1:0] mid;

	// clamp sizes to 1..store width and 1..MAX_HEIGHT
	always_comb begin
		w_eff = CNT_W'(frame_width);
		if (w_eff == '0) begin
			w_eff = CNT_W'(1);
		end else if (w_eff > CNT_W'(MAX_WIDTH)) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end
		h_eff = CNT_W'(frame_height);
		if (h_eff == '0) begin
			h_eff = CNT_W'(1);
		end else if (h_eff > CNT_W'(MAX_HEIGHT)) begin
			h_eff = CNT_W'(MAX_HEIGHT);
		end
	end

	assign row_end   = (CNT_W'(x_q) + CNT_W'(1)) >= w_eff;
	assign frame_end = row_end && ((CNT_W'(y_q) + CNT_W'(1)) >= h_eff);

	assign push     = v_s1 && !fifo_full;
	assign s_tready = !clr_q && (!v_s1 || !fifo_full);
	assign accept   = s_tvalid && s_tready;
	assign fwd_hit  = push && (x_s1 == x_q);

	// raster position and store clearing after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(MAX_WIDTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				if (row_end) begin
					x_q <= '0;
					y_q <= frame_end ? '0 : y_q + ROW_W'(1);
				end else begin
					x_q <= x_q + AW'(1);
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// request fields for the stage after the store read
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_q;
			px_s1   <= pixel;
			y1_s1   <= (y_q != '0);
			y2_s1   <= (y_q > ROW_W'(1));
			emit_s1 <= (x_q != '0) && (y_q != '0);
			last_s1 <= frame_end;
			fwd_s1  <= fwd_hit;
		end
	end

	// line store: both lines share one word per column
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (push) begin
			mem[x_s1] <= {mid, px_s1};
		end
		if (accept) begin
			rd_q       <= mem[x_q];
			fwd_data_q <= {mid, px_s1};
		end
	end

	// same column written one request earlier comes from the bypass
	always_comb begin
		rdata = fwd_s1 ? fwd_data_q : rd_q;
		top   = y2_s1 ? $signed(rdata[2*PIX_W-1:PIX_W]) : '0;
		mid   = y1_s1 ? $signed(rdata[PIX_W-1:0]) : '0;
	end

	always_comb begin
		push_item.top  = top;
		push_item.mid  = mid;
		push_item.px   = px_s1;
		push_item.emit = emit_s1;
		push_item.last = last_s1;
	end

endmodule

>>> hdl/lbc_fifo.sv
`timescale 1ns / 1ps
module lbc_fifo import lbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lbc_item_t push_item,
	output logic      full,
	input  logic      pop,
	output lbc_item_t pop_item,
	output logic      not_empty
);

	lbc_item_t               buf_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = buf_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> hdl/lbc_back.sv
`timescale 1ns / 1ps
module lbc_back import lbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   not_empty,
	input  lbc_item_t              pop_item,
	output logic                   pop,
	input  coef_t                  coef,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	logic signed [PIX_W-1:0]    win_q [KERNEL][KERNEL];
	logic signed [PROD_W-1:0]   prod [KERNEL][KERNEL];
	logic signed [PROD_W-1:0]   prod_s2 [KERNEL][KERNEL];
	logic signed [ROWSUM_W-1:0] row_s3 [KERNEL];
	logic signed [SUM_W-1:0]    sum_q;
	logic                       adv;
	logic                       v_s1;
	logic                       last_s1;
	logic                       v_s2;
	logic                       last_s2;
	logic                       v_s3;
	logic                       last_s3;
	logic                       m_valid_q;
	logic                       m_last_q;

	// the whole pipeline moves unless a result waits on m_tready
	assign adv = !m_valid_q || m_tready;
	assign pop = not_empty && adv;

	// window shift and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KERNEL; i++) begin
				for (int j = 0; j < KERNEL; j++) begin
					win_q[i][j] <= '0;
				end
			end
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				for (int i = 0; i < KERNEL; i++) begin
					for (int j = 0; j < KERNEL - 1; j++) begin
						win_q[i][j] <= win_q[i][j+1];
					end
				end
				win_q[0][KERNEL-1] <= pop_item.top;
				win_q[1][KERNEL-1] <= pop_item.mid;
				win_q[2][KERNEL-1] <= pop_item.px;
			end
			if (adv) begin
				v_s1      <= pop && pop_item.emit;
				v_s2      <= v_s1;
				v_s3      <= v_s2;
				m_valid_q <= v_s3;
			end
		end
	end

	// nine taps times coefficients
	always_comb begin
		for (int i = 0; i < KERNEL; i++) begin
			for (int j = 0; j < KERNEL; j++) begin
				prod[i][j] = win_q[i][j] * $signed(coef[i][COEF_W*j +: COEF_W]);
			end
		end
	end

	// product, row sum and total stages
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= pop_item.last;
			for (int i = 0; i < KERNEL; i++) begin
				for (int j = 0; j < KERNEL; j++) begin
					prod_s2[i][j] <= prod[i][j];
				end
				row_s3[i] <= ROWSUM_W'(prod_s2[i][0]) + ROWSUM_W'(prod_s2[i][1])
					+ ROWSUM_W'(prod_s2[i][2]);
			end
			last_s2  <= last_s1;
			last_s3  <= last_s2;
			sum_q    <= SUM_W'(row_s3[0]) + SUM_W'(row_s3[1]) + SUM_W'(row_s3[2]);
			m_last_q <= last_s3;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - SUM_W){1'b0}}, sum_q};
	assign m_tlast  = m_last_q;

endmodule

>>> hdl/line_buffer_convolution_3x3.sv
// 3x3 convolution over a raster stream of signed 16-bit pixels.
// Input stream s_*: one pixel per request in s_tdata[15:0].
// Output stream m_*: m_tdata[35:0] is the signed sum of the nine window
// products, m_tlast marks the result of the last pixel of a frame.
// A result comes for every pixel at row >= 1 and column >= 1; other pixels
// only fill the line store and the window.
// Throughput: one pixel per clock unless m_tready stalls, set by the line
// store (one read port and one write port, each used once per cycle) and
// the nine parallel multipliers.
// A 4-entry queue parts the line store front from the multiply back, so a
// stalled m_tready fills the queue first and only then drops s_tready.
// The APB port holds the three coefficient rows (48 bits, at 0x00, 0x08,
// 0x10), frame_width (0x18) and frame_height (0x20); write only while idle.
// After reset the line store is cleared word by word, during which
// s_tready stays low; APB writes are taken at any time.
`timescale 1ns / 1ps
module line_buffer_convolution_3x3 import lbc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,   // [15:0] pixel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [35:0] conv_sum, [39:36] zero
	output logic                   m_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready
);

	coef_t           coef_q;
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [2:0]      reg_idx;
	logic            cfg_wr;
	logic            push;
	lbc_item_t       push_item;
	logic            fifo_full;
	logic            pop;
	lbc_item_t       pop_item;
	logic            not_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q         <= '0;
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COEF_TOP:    coef_q[0] <= pwdata[COEF_ROW_W-1:0];
				REG_COEF_MID:    coef_q[1] <= pwdata[COEF_ROW_W-1:0];
				REG_COEF_BOTTOM: coef_q[2] <= pwdata[COEF_ROW_W-1:0];
				REG_WIDTH:       frame_width_q <= pwdata[FW_W-1:0];
				REG_HEIGHT:      frame_height_q <= pwdata[FH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_COEF_TOP:    prdata = CFG_DATA_W'(coef_q[0]);
			REG_COEF_MID:    prdata = CFG_DATA_W'(coef_q[1]);
			REG_COEF_BOTTOM: prdata = CFG_DATA_W'(coef_q[2]);
			REG_WIDTH:       prdata = CFG_DATA_W'(frame_width_q);
			REG_HEIGHT:      prdata = CFG_DATA_W'(frame_height_q);
			default:         prdata = '0;
		endcase
	end

	lbc_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.pixel        ($signed(s_tdata)),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.push         (push),
		.push_item    (push_item),
		.fifo_full    (fifo_full)
	);

	lbc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	lbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_item  (pop_item),
		.pop       (pop),
		.coef      (coef_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

>>> hdl/lbc_checker.sv
`timescale 1ns / 1ps
module lbc_checker import lbc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [PIX_W-1:0]       s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [CFG_ADDR_W-1:0]  paddr,
	input logic [CFG_DATA_W-1:0]  pwdata,
	input logic [CFG_DATA_W-1:0]  prdata,
	input logic                   pready
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// sum padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:SUM_W] == '0)
		else $error("tdata padding not zero");

	// the config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// width written then read back gives the written bits
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[5:3] == REG_WIDTH)
		##1 (psel && !pwrite && paddr[5:3] == REG_WIDTH)
		|-> prdata == CFG_DATA_W'($past(pwdata[FW_W-1:0])))
		else $error("frame_width readback mismatch");

endmodule

bind line_buffer_convolution_3x3 lbc_checker u_lbc_checker (.*);

>>> sim/line_buffer_convolution_3x3_tb.sv
`timescale 1ns / 1ps
module line_buffer_convolution_3x3_tb;
	import lbc_pkg::*;

	localparam int HANG_LIMIT = 5000;
	localparam int DRAIN      = 16;

	typedef enum logic {OP_WRITE, OP_PIXEL} dir_op_t;

	typedef struct {
		dir_op_t     op;
		logic [2:0]  idx;
		logic [63:0] value;
		bit          typed;
		logic [35:0] exp_sum;
		bit          exp_last;
	} dir_row_t;

	typedef struct packed {
		logic [35:0] sum;
		logic        last;
	} conv_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [PIX_W-1:0]       s_tdata = '0;      // [15:0] pixel
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;           // [35:0] conv_sum, [39:36] zero
	logic                   m_tlast;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr = '0;
	logic [CFG_DATA_W-1:0]  pwdata = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	// predictor state
	logic [47:0]        coef_row [3];
	logic [10:0]        width_reg;
	logic [12:0]        height_reg;
	logic signed [15:0] row_two_up [DEF_MAX_WIDTH];
	logic signed [15:0] row_one_up [DEF_MAX_WIDTH];
	logic signed [15:0] win [3][3];
	int unsigned        col_pos;
	int unsigned        row_pos;

	conv_result_t expected_sums[$];
	dir_row_t     dir_rows[$];

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int sums_checked = 0;
	int pixels_sent = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;

	line_buffer_convolution_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// one pixel through the window and line stores
	function automatic void conv_window_step(input logic signed [15:0] px, output bit emit,
			output logic [35:0] sum, output bit last);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		int unsigned xi;
		logic signed [15:0] top;
		logic signed [15:0] mid;
		longint acc;
		bit row_end;
		w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		x = col_pos;
		y = row_pos;
		xi = (x < DEF_MAX_WIDTH) ? x : 0;
		// rows not yet written in this frame read as zero
		top = (y >= 2) ? row_two_up[xi] : 16'sd0;
		mid = (y >= 1) ? row_one_up[xi] : 16'sd0;
		row_end = (x + 1 >= w);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 2; j++)
				win[i][j] = win[i][j+1];
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		row_two_up[xi] = mid;
		row_one_up[xi] = px;
		acc = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				acc += longint'(win[i][j]) * longint'($signed(coef_row[i][16*j +: 16]));
		emit = (x >= 1) && (y >= 1);
		sum = acc[35:0];
		last = row_end && (y + 1 >= h);
		// counters wrap at the row and frame end
		if (row_end) begin
			col_pos = 0;
			row_pos = last ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
	endfunction

	function automatic void add_row(input dir_op_t op, input logic [2:0] idx,
			input logic [63:0] value, input bit typed, input logic [35:0] exp_sum,
			input bit exp_last);
		dir_row_t r;
		r.op = op;
		r.idx = idx;
		r.value = value;
		r.typed = typed;
		r.exp_sum = exp_sum;
		r.exp_last = exp_last;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [47:0] pick_coef(input int mode);
		logic [47:0] c;
		case (mode)
			0: c = 48'({$urandom, $urandom});
			1: c = 48'h8000_8000_8000;
			2: c = 48'h7FFF_7FFF_7FFF;
			default: begin
				for (int j = 0; j < 3; j++)
					c[16*j +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			end
		endcase
		return c;
	endfunction

	// apb write: setup, access, then a return to idle
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_COEF_TOP:    coef_row[0] = value[47:0];
			REG_COEF_MID:    coef_row[1] = value[47:0];
			REG_COEF_BOTTOM: coef_row[2] = value[47:0];
			REG_WIDTH:       width_reg = value[10:0];
			REG_HEIGHT:      height_reg = value[12:0];
			default: ;
		endcase
		cfg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every expected sum and trailing pixel drain out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic push_pixel(input logic [15:0] pix, input bit typed,
			input logic [35:0] t_sum, input bit t_last);
		bit emit;
		bit last;
		logic [35:0] sum;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pixels_sent++;
		conv_window_step(pix, emit, sum, last);
		if (emit)
			expected_sums.push_back(typed ? {t_sum, t_last} : {sum, last});
	endtask

	task automatic run_phase(input logic [10:0] w, input logic [12:0] h, input int coef_mode,
			input int idle_pct, input int stall, input int n, input int pause_at);
		logic [15:0] pix;
		wait_idle();
		reg_write(REG_COEF_TOP, 64'(pick_coef(coef_mode)));
		reg_write(REG_COEF_MID, 64'(pick_coef(coef_mode)));
		reg_write(REG_COEF_BOTTOM, 64'(pick_coef(coef_mode)));
		reg_write(REG_WIDTH, 64'(w));
		reg_write(REG_HEIGHT, 64'(h));
		sender_idle_pct = idle_pct;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			// at pause_at, hold off until the block has handed back every sum
			if (i == pause_at)
				wait_idle();
			case ($urandom_range(7))
				0: pix = 16'h8000;
				1: pix = 16'h7FFF;
				2: pix = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
				default: pix = 16'($urandom);
			endcase
			push_pixel(pix, 1'b0, '0, 1'b0);
		end
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// result checker
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sum %0d last %0b", $signed(m_tdata[35:0]), m_tlast);
			end else begin
				want = expected_sums.pop_front();
				sums_checked++;
				if (m_tdata !== {4'b0000, want.sum} || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sum mismatch: expected %0d last %0b, got %0d (tdata %h) last %0b",
							$signed(want.sum), want.last, $signed(m_tdata[35:0]), m_tdata, m_tlast);
				end
			end
		end
	end

	// hang detection
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("no handshake for %0d cycles, %0d sums outstanding", quiet_cycles,
				expected_sums.size());
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int k;
		int ip;
		int sp;
		// predictor reset state
		coef_row[0] = '0;
		coef_row[1] = '0;
		coef_row[2] = '0;
		width_reg = FW_RESET;
		height_reg = FH_RESET;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
			row_two_up[i] = '0;
			row_one_up[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;

		// reset geometry 7x7 and a zero kernel: every sum is zero
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h7FFF, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h8000, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h0000, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h0001, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'hFFFF, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h5555, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'hAAAA, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h7FFF, 1'b0, '0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h8000, 1'b1, 36'd0, 1'b0);
		add_row(OP_PIXEL, REG_COEF_TOP, 64'h3039, 1'b1, 36'd0, 1'b0);
		// most negative kernel, geometry shrunk mid-row so the counters wrap
		add_row(OP_WRITE, REG_COEF_TOP, 64'h8000_8000_8000, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_COEF_MID, 64'h8000_8000_8000, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_COEF_BOTTOM, 64'h8000_8000_8000, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_WIDTH, 64'd3, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_HEIGHT, 64'd3, 1'b0, '0, 1'b0);
		for (int i = 0; i < 4; i++)
			add_row(OP_PIXEL, REG_COEF_TOP, 64'h8000, 1'b0, '0, 1'b0);
		// most positive kernel against extreme pixels over a whole frame
		add_row(OP_WRITE, REG_COEF_TOP, 64'h7FFF_7FFF_7FFF, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_COEF_MID, 64'h7FFF_7FFF_7FFF, 1'b0, '0, 1'b0);
		add_row(OP_WRITE, REG_COEF_BOTTOM, 64'h7FFF_7FFF_7FFF, 1'b0, '0, 1'b0);
		for (int i = 0; i < 6; i++)
			add_row(OP_PIXEL, REG_COEF_TOP, 64'h8000, 1'b0, '0, 1'b0);
		for (int i = 0; i < 3; i++)
			add_row(OP_PIXEL, REG_COEF_TOP, 64'h7FFF, 1'b0, '0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == OP_WRITE) begin
				wait_idle();
				reg_write(dir_rows[i].idx, dir_rows[i].value);
			end else begin
				push_pixel(dir_rows[i].value[15:0], dir_rows[i].typed, dir_rows[i].exp_sum,
					dir_rows[i].exp_last);
			end
		end

		// random part, one register setting per phase
		run_phase(11'd3, 13'd3, 0, 0, 0, 60, -1);
		run_phase(11'd7, 13'd5, 1, 73, 0, 60, -1);
		run_phase(11'd16, 13'd4, 0, 0, 73, 60, -1);
		run_phase(11'd5, 13'd3, 2, 22, 22, 60, 30);
		run_phase(11'd0, 13'd4, 0, 0, 0, 20, -1);
		run_phase(11'd4, 13'd0, 0, 22, 22, 20, -1);
		run_phase(11'd2047, 13'd2, 0, 0, 0, 1030, -1);
		run_phase(11'd1024, 13'd2, 3, 0, 0, 40, -1);
		run_phase(11'd11, 13'd4096, 0, 0, 73, 60, -1);
		run_phase(11'd6, 13'd8191, 0, 73, 0, 30, -1);
		// height cut below the current row while inside a frame
		run_phase(11'd9, 13'd3, 0, 22, 22, 50, 20);
		for (int p = 0; p < 4; p++) begin
			k = $urandom_range(3);
			ip = (k == 1 || k == 3) ? ((k == 1) ? 73 : 22) : 0;
			sp = (k == 2 || k == 3) ? ((k == 2) ? 73 : 22) : 0;
			run_phase(11'($urandom_range(12, 3)), 13'($urandom_range(6, 3)),
				$urandom_range(3), ip, sp, 10, -1);
		end

		wait_idle();
		$display("sent %0d pixels and checked %0d sums over %0d register writes", pixels_sent,
			sums_checked, cfg_writes);
		$display("widths 1 to 1024 with clamping, heights 1 to 4096, extreme kernels, stalls");
		if (mismatches == 0 && expected_sums.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d sums missing", mismatches, expected_sums.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/lbc_pkg.sv
hdl/lbc_front.sv
hdl/lbc_fifo.sv
hdl/lbc_back.sv
hdl/line_buffer_convolution_3x3.sv
hdl/lbc_checker.sv
sim/line_buffer_convolution_3x3_tb.sv
